FILE: design/whc_pkg.sv
// Shared constants, types and helpers for the windowed health classifier.
package whc_pkg;

  localparam int unsigned WINDOW_SAMPLES = 16;
  localparam int unsigned NUM_ENDPOINTS  = 8;

  localparam int unsigned EP_W      = 3;
  localparam int unsigned LAT_IN_W  = 32;
  localparam int unsigned LAT_W     = 31;
  localparam int unsigned CNT_W     = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned HEAD_W    = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int unsigned EP_IDX_W  = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
  localparam int unsigned SUM_W     = LAT_W + $clog2(WINDOW_SAMPLES);
  localparam int unsigned RING_DEPTH = NUM_ENDPOINTS * WINDOW_SAMPLES;
  localparam int unsigned RING_AW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned DCNT_W    = $clog2(SUM_W + 1);

  localparam int unsigned IN_BITS   = EP_W + 1 + LAT_IN_W;
  localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = EP_W + CNT_W + CNT_W + LAT_W + STATUS_W;
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [LAT_W-1:0] SLOW_THRESHOLD_RST = LAT_W'(200000);

  localparam logic [STATUS_W-1:0] STATUS_HEALTHY   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEGRADED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNHEALTHY = 2'd2;

  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic div_step;
    logic finish;
  } whc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } whc_status_t;

  function automatic logic [EP_W-1:0] ep_reduce(input logic [EP_W-1:0] raw);
    logic [EP_W:0] v;
    v = {1'b0, raw};
    for (int i = 0; i < (1 << EP_W); i++) begin
      if (v >= (EP_W+1)'(NUM_ENDPOINTS)) begin
        v = v - (EP_W+1)'(NUM_ENDPOINTS);
      end
    end
    return v[EP_W-1:0];
  endfunction

endpackage

FILE: design/whc_ctrl.sv
// Sequencing state machine for the windowed health classifier.
module whc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  whc_pkg::whc_status_t status_i,
  output whc_pkg::whc_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: design/whc_datapath.sv
// Window storage, running sums, serial divider and result register.
module whc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  whc_pkg::whc_cmd_t            cmd_i,
  output whc_pkg::whc_status_t         status_o,
  input  logic [whc_pkg::IN_W-1:0]     in_data_i,
  input  logic                         cfg_we_i,
  input  logic [whc_pkg::LAT_W-1:0]    cfg_wdata_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [whc_pkg::OUT_W-1:0]    out_data_o
);

  localparam int unsigned LW = whc_pkg::LAT_W;
  localparam int unsigned SW = whc_pkg::SUM_W;
  localparam int unsigned CW = whc_pkg::CNT_W;
  localparam int unsigned HW = whc_pkg::HEAD_W;

  logic [LW-1:0]              thresh_q;
  logic [whc_pkg::EP_W-1:0]   ep_q;
  logic                       ok_q;
  logic [LW-1:0]              lat_q;

  logic [HW-1:0] head_q  [whc_pkg::NUM_ENDPOINTS];
  logic [CW-1:0] fill_q  [whc_pkg::NUM_ENDPOINTS];
  logic [SW-1:0] sum_q   [whc_pkg::NUM_ENDPOINTS];
  logic [CW-1:0] fails_q [whc_pkg::NUM_ENDPOINTS];

  logic [LW:0] ring_mem [whc_pkg::RING_DEPTH];
  logic [LW:0] ring_rd_q;

  logic [CW-1:0]                div_n_q;
  logic [CW-1:0]                div_rem_q;
  logic [SW-1:0]                div_quo_q;
  logic [whc_pkg::DCNT_W-1:0]   div_cnt_q;
  logic [CW-1:0]                res_errs_q;

  logic                       out_valid_q;
  logic [whc_pkg::OUT_W-1:0]  out_data_q;

  logic [whc_pkg::EP_IDX_W-1:0] ep_idx;
  logic [whc_pkg::RING_AW-1:0]  ring_addr;
  logic [HW-1:0]  cur_head, new_head;
  logic [CW-1:0]  cur_fill, new_fill, cur_fails, fails_base, new_fails;
  logic [SW-1:0]  cur_sum, sum_base, new_sum;
  logic           full;
  logic [LW-1:0]  in_lat;
  logic [CW:0]    rem_sh;
  logic           rem_ge;
  logic [CW:0]    rem_sub;
  logic [LW-1:0]  avg;
  logic [whc_pkg::STATUS_W-1:0] health;

  assign ep_idx    = whc_pkg::EP_IDX_W'(ep_q);
  assign cur_head  = head_q[ep_idx];
  assign cur_fill  = fill_q[ep_idx];
  assign cur_sum   = sum_q[ep_idx];
  assign cur_fails = fails_q[ep_idx];
  assign ring_addr = whc_pkg::RING_AW'(ep_idx) * whc_pkg::RING_AW'(whc_pkg::WINDOW_SAMPLES)
                   + whc_pkg::RING_AW'(cur_head);

  assign full       = (cur_fill >= CW'(whc_pkg::WINDOW_SAMPLES));
  assign sum_base   = full ? (cur_sum - SW'(ring_rd_q[LW-1:0])) : cur_sum;
  assign new_sum    = sum_base + SW'(lat_q);
  assign fails_base = (full && ring_rd_q[LW] && (cur_fails != '0)) ? (cur_fails - CW'(1))
                                                                   : cur_fails;
  assign new_fails  = ok_q ? fails_base : (fails_base + CW'(1));
  assign new_fill   = full ? cur_fill : (cur_fill + CW'(1));
  assign new_head   = (cur_head == HW'(whc_pkg::WINDOW_SAMPLES - 1)) ? '0
                                                                     : (cur_head + HW'(1));

  assign in_lat = in_data_i[whc_pkg::EP_W + whc_pkg::LAT_IN_W] ? '0
                : in_data_i[whc_pkg::EP_W + 1 +: LW];

  assign rem_sh  = {div_rem_q, div_quo_q[SW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_n_q});
  assign rem_sub = rem_sh - {1'b0, div_n_q};

  assign avg = div_quo_q[LW-1:0];

  always_comb begin
    priority if ({res_errs_q, 1'b0} >= {1'b0, div_n_q}) begin
      health = whc_pkg::STATUS_UNHEALTHY;
    end else if ((res_errs_q != '0) || (avg > thresh_q)) begin
      health = whc_pkg::STATUS_DEGRADED;
    end else begin
      health = whc_pkg::STATUS_HEALTHY;
    end
  end

  assign status_o.div_done = (div_cnt_q == whc_pkg::DCNT_W'(SW));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= whc_pkg::SLOW_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ep_q  <= whc_pkg::ep_reduce(in_data_i[whc_pkg::EP_W-1:0]);
      ok_q  <= in_data_i[whc_pkg::EP_W];
      lat_q <= in_lat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < whc_pkg::NUM_ENDPOINTS; i++) begin
        head_q[i]  <= '0;
        fill_q[i]  <= '0;
        sum_q[i]   <= '0;
        fails_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      head_q[ep_idx]  <= new_head;
      fill_q[ep_idx]  <= new_fill;
      sum_q[ep_idx]   <= new_sum;
      fails_q[ep_idx] <= new_fails;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      ring_mem[ring_addr] <= {!ok_q, lat_q};
    end
    if (cmd_i.read) begin
      ring_rd_q <= ring_mem[ring_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      div_n_q    <= new_fill;
      div_rem_q  <= '0;
      div_quo_q  <= new_sum;
      res_errs_q <= new_fails;
    end else if (cmd_i.div_step) begin
      div_rem_q <= rem_ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
      div_quo_q <= {div_quo_q[SW-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.update) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + whc_pkg::DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= whc_pkg::OUT_W'({health, avg, res_errs_q, div_n_q, ep_q});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/windowed_health_classifier.sv
// Top level of the windowed endpoint health classifier.
// Takes one probe report at a time and returns one statistics transfer per report. After a
// report is accepted, the ring memory is read and the endpoint state updated, then a
// one-bit-per-cycle restoring divider forms the window average; completion is detected and
// the result is loaded into the result register. The input reopens in the cycle after the
// result is loaded, so a new report is only taken once the previous result has been loaded.
// A finished result waits in that register while the next report is taken; results stall
// only when the previous one has not been taken by the time the next finishes. The threshold
// write port may be used only while no report is in flight.
module windowed_health_classifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] endpoint_id, [3] probe_ok, [35:4] latency_sample, [39:36] zero
  input  logic [whc_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] endpoint_echo, [7:3] sample_count, [12:8] error_count,
  // [43:13] average_latency, [45:44] health_status, [47:46] zero
  output logic [whc_pkg::OUT_W-1:0]     m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [whc_pkg::LAT_W-1:0]     cfg_wdata_i
);

  whc_pkg::whc_cmd_t    cmd;
  whc_pkg::whc_status_t status;

  whc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  whc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: design/whc_checker.sv
// Port-level checks for the windowed health classifier, bound to the top level.
module whc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [whc_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic [4:0] n_obs, e_obs;
  logic [1:0] st_obs;

  assign n_obs  = m_axis_tdata[7:3];
  assign e_obs  = m_axis_tdata[12:8];
  assign st_obs = m_axis_tdata[45:44];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("report taken while another is in flight");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (n_obs != 5'd0) && (e_obs <= n_obs))
    else $error("window counts inconsistent");

  a_unhealthy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ({e_obs, 1'b0} >= {1'b0, n_obs}) |-> st_obs == whc_pkg::STATUS_UNHEALTHY)
    else $error("status misses error majority");

  a_degraded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ({e_obs, 1'b0} < {1'b0, n_obs}) && (e_obs != 5'd0)
      |-> st_obs == whc_pkg::STATUS_DEGRADED)
    else $error("status misses failed probes");

endmodule

bind windowed_health_classifier whc_checker u_whc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/windowed_health_classifier_tb.sv
// Testbench for the windowed health classifier: probe reports checked against a predictor.
module windowed_health_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import whc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned MAX_SHOWN    = 10;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned HOLD_AT_A    = 200;
  localparam int unsigned HOLD_AT_B    = 1100;

  typedef struct packed {
    logic [EP_W-1:0]     endpoint;
    logic [CNT_W-1:0]    samples;
    logic [CNT_W-1:0]    errors;
    logic [LAT_W-1:0]    average;
    logic [STATUS_W-1:0] status;
  } stats_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [LAT_W-1:0]   cfg_wdata_i   = '0;

  // predictor state
  logic [LAT_W-1:0]   lat_ring  [NUM_ENDPOINTS][WINDOW_SAMPLES];
  logic               fail_ring [NUM_ENDPOINTS][WINDOW_SAMPLES];
  logic [HEAD_W-1:0]  ring_pos  [NUM_ENDPOINTS];
  logic [CNT_W-1:0]   fill      [NUM_ENDPOINTS];
  logic [SUM_W-1:0]   lat_sum   [NUM_ENDPOINTS];
  logic [CNT_W-1:0]   fail_cnt  [NUM_ENDPOINTS];
  logic [LAT_W-1:0]   slow_thr  = SLOW_THRESHOLD_RST;

  logic [IN_W-1:0]    reports_pending [$];
  stats_t             stats_due [$];

  bit                 in_taken       = 1'b0;
  int unsigned        reports_queued = 0;
  int unsigned        results_seen   = 0;
  int unsigned        mismatches     = 0;
  int unsigned        cycle_count    = 0;

  int unsigned        gap_left   = 0;
  int unsigned        burst_left = 0;
  int unsigned        stall_left = 0;
  int unsigned        mode_left  = 0;
  int unsigned        rx_mode    = 0;
  int unsigned        hold_mark  = 0;

  windowed_health_classifier uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic stats_t classify_report(input logic [IN_W-1:0] word);
    logic [EP_W-1:0]     ep;
    logic                failed;
    logic [LAT_IN_W-1:0] raw;
    logic [LAT_W-1:0]    lat;
    logic [HEAD_W-1:0]   slot;
    stats_t              r;
    ep     = EP_W'(word[EP_W-1:0] % NUM_ENDPOINTS);
    failed = !word[EP_W];
    raw    = word[EP_W+1 +: LAT_IN_W];
    lat    = raw[LAT_IN_W-1] ? '0 : raw[LAT_W-1:0];
    slot   = ring_pos[ep];
    if (fill[ep] >= WINDOW_SAMPLES) begin
      // retire the oldest sample from the slot about to be overwritten
      lat_sum[ep] = lat_sum[ep] - lat_ring[ep][slot];
      if (fail_ring[ep][slot] && fail_cnt[ep] != 0) begin
        fail_cnt[ep] = fail_cnt[ep] - 1'b1;
      end
    end else begin
      fill[ep] = fill[ep] + 1'b1;
    end
    lat_ring[ep][slot]  = lat;
    fail_ring[ep][slot] = failed;
    lat_sum[ep]         = lat_sum[ep] + lat;
    if (failed) begin
      fail_cnt[ep] = fail_cnt[ep] + 1'b1;
    end
    ring_pos[ep] = HEAD_W'((slot + 1) % WINDOW_SAMPLES);
    r.endpoint = ep;
    r.samples  = fill[ep];
    r.errors   = fail_cnt[ep];
    r.average  = LAT_W'(lat_sum[ep] / fill[ep]);
    if (2 * fail_cnt[ep] >= fill[ep]) begin
      r.status = STATUS_UNHEALTHY;
    end else if (fail_cnt[ep] != 0 || r.average > slow_thr) begin
      r.status = STATUS_DEGRADED;
    end else begin
      r.status = STATUS_HEALTHY;
    end
    return r;
  endfunction

  task automatic check_stats(input logic [OUT_W-1:0] word);
    stats_t got;
    stats_t want;
    got.endpoint = word[0 +: EP_W];
    got.samples  = word[EP_W +: CNT_W];
    got.errors   = word[EP_W+CNT_W +: CNT_W];
    got.average  = word[EP_W+2*CNT_W +: LAT_W];
    got.status   = word[EP_W+2*CNT_W+LAT_W +: STATUS_W];
    if (stats_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("result %0d arrived with nothing outstanding: %h", results_seen, word);
      end
    end else begin
      want = stats_due[0];
      stats_due.delete(0);
      if (got.endpoint !== want.endpoint || got.samples !== want.samples ||
          got.errors !== want.errors || got.average !== want.average ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("result %0d: expected ep %0d n %0d err %0d avg %0d status %0d",
                   results_seen, want.endpoint, want.samples, want.errors, want.average,
                   want.status);
          $display("           got      ep %0d n %0d err %0d avg %0d status %0d",
                   got.endpoint, got.samples, got.errors, got.average, got.status);
        end
      end
    end
  endtask

  // sample both sides and the threshold port
  always @(posedge clk_i) begin
    in_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (cfg_we_i) begin
        slow_thr = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_stats(m_axis_tdata);
        results_seen++;
      end
      if (in_taken) begin
        stats_due.insert(stats_due.size(), classify_report(s_axis_tdata));
      end
    end
  end

  // sender: bursts of reports separated by random gaps
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (reports_pending.size() != 0) begin
        s_axis_tdata  <= reports_pending[0];
        reports_pending.delete(0);
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern with changing modes, plus two long hold-offs
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ((results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) &&
                 hold_mark != results_seen) begin
      hold_mark     <= results_seen;
      stall_left    <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= $urandom_range(0, 1);
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 4) == 0);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_report(input logic [EP_W-1:0] ep, input logic ok,
                             input logic [LAT_IN_W-1:0] lat);
    reports_pending.insert(reports_pending.size(), IN_W'({lat, ok, ep}));
    reports_queued++;
  endtask

  task automatic wait_drained();
    while (results_seen != reports_queued) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_threshold(input logic [LAT_W-1:0] value);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic queue_random_reports(input int unsigned count, input int unsigned fail_pct);
    logic [EP_W-1:0]     ep;
    logic                ok;
    logic [LAT_IN_W-1:0] lat;
    longint              v;
    for (int unsigned i = 0; i < count; i++) begin
      ep = EP_W'($urandom_range(0, (1 << EP_W) - 1));
      ok = ($urandom_range(0, 99) >= fail_pct);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // hover around the threshold
          v = longint'(slow_thr) + longint'($urandom_range(0, 2000)) - 64'sd1000;
          if (v < 0) begin
            v = 0;
          end else if (v > 64'sh7FFF_FFFF) begin
            v = 64'sh7FFF_FFFF;
          end
          lat = v[LAT_IN_W-1:0];
        end
        4, 5: begin
          lat = {1'b1, LAT_W'($urandom)};
        end
        6: begin
          lat = 32'h7FFF_FFFF - (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255));
        end
        default: begin
          lat = $urandom;
        end
      endcase
      push_report(ep, ok, lat);
    end
  endtask

  initial begin
    for (int e = 0; e < NUM_ENDPOINTS; e++) begin
      ring_pos[e] = '0;
      fill[e]     = '0;
      lat_sum[e]  = '0;
      fail_cnt[e] = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset threshold still in effect
    push_report(3'd0, 1'b1, 32'd0);
    push_report(3'd0, 1'b1, 32'd200000);
    push_report(3'd0, 1'b1, 32'd500000);
    push_report(3'd1, 1'b0, 32'hFFFF_FFFF);
    push_report(3'd2, 1'b1, 32'h8000_0000);
    push_report(3'd2, 1'b1, 32'h7FFF_FFFF);
    push_report(3'd3, 1'b1, 32'h7FFF_FFFF);
    push_report(3'd3, 1'b1, 32'h7FFF_FFFF);
    push_report(3'd7, 1'b0, 32'h7FFF_FFFF);
    push_report(3'd4, 1'b1, 32'd200000);
    push_report(3'd4, 1'b1, 32'd200001);
    push_report(3'd5, 1'b1, 32'd200001);
    push_report(3'd6, 1'b1, 32'd100);
    push_report(3'd6, 1'b1, 32'd100);
    push_report(3'd6, 1'b0, 32'd100);
    push_report(3'd6, 1'b0, 32'd100);
    push_report(3'd7, 1'b1, 32'd0);
    push_report(3'd5, 1'b1, 32'd199999);
    push_report(3'd1, 1'b1, 32'h8000_0001);

    write_threshold('0);
    queue_random_reports(300, 15);
    write_threshold('1);
    queue_random_reports(350, 0);
    write_threshold(LAT_W'(200000));
    queue_random_reports(400, 3);
    write_threshold(LAT_W'($urandom));
    queue_random_reports(350, 40);
    write_threshold(LAT_W'(1));
    queue_random_reports(330, 8);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && stats_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/whc_pkg.sv
design/whc_ctrl.sv
design/whc_datapath.sv
design/windowed_health_classifier.sv
design/whc_checker.sv
verif/windowed_health_classifier_tb.sv
